@@ rtl/source_token_scanner_core_macros.svh @@
// Assertion macros for the token scanner.
`ifndef SOURCE_TOKEN_SCANNER_CORE_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define STS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STS_ASSERT(label, clk, rst_n, prop, msg)
`define STS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ rtl/sts_pkg.sv @@
package sts_pkg;

  localparam int unsigned MAX_RES = 4;

  typedef enum logic [6:0] {
    K_IDENT = 7'd0, K_NUMBER = 7'd1, K_STRING = 7'd2, K_CHAR = 7'd3, K_EOF = 7'd4,
    K_UNKNOWN = 7'd5, K_ERROR = 7'd6, K_KW0 = 7'd7, K_PLUS = 7'd29, K_DOT = 7'd47,
    K_DOTDOT = 7'd48, K_COMMA = 7'd49, K_AMP = 7'd61, K_PIPE = 7'd65, K_LESS = 7'd69,
    K_GREATER = 7'd73, K_SLASH = 7'd77, K_NONE = 7'd127
  } kind_t;

  typedef enum logic [11:0] {
    M_IDLE      = 12'b000000000001,
    M_IDENT     = 12'b000000000010,
    M_NUM       = 12'b000000000100,
    M_NUM_DOT   = 12'b000000001000,
    M_OP        = 12'b000000010000,
    M_STR       = 12'b000000100000,
    M_STR_ESC   = 12'b000001000000,
    M_STR_HEX   = 12'b000010000000,
    M_LINE      = 12'b000100000000,
    M_BLK       = 12'b001000000000,
    M_BLK_SLASH = 12'b010000000000,
    M_BLK_STAR  = 12'b100000000000
  } mode_t;

  typedef logic [7:0] kw_word_t [8];

  function automatic logic [63:0] kw_str(input int unsigned i);
    logic [63:0] s;
    s = '0;
    unique case (i)
      0:  s = "alias";   1: s = "alignof"; 2: s = "break";  3: s = "case";
      4:  s = "cast";    5: s = "const";   6: s = "continue"; 7: s = "default";
      8:  s = "do";      9: s = "else";   10: s = "enum";   11: s = "for";
      12: s = "fun";    13: s = "if";     14: s = "offsetof"; 15: s = "return";
      16: s = "sizeof"; 17: s = "struct"; 18: s = "switch"; 19: s = "union";
      20: s = "var";    default: s = "while";
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(input int unsigned i);
    logic [63:0] s;
    logic [3:0] n;
    s = kw_str(i);
    n = 4'd0;
    for (int j = 0; j < 8; j++) begin
      if (s[8*j +: 8] != 8'd0) n = 4'(j + 1);
    end
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic logic is_skip(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13) || b == 8'hC2 || b == 8'hA0;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] h;
    h = 5'h10;
    if (is_digit(b)) h = {1'b0, 4'(b - "0")};
    else if (b >= "a" && b <= "f") h = {1'b0, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") h = {1'b0, 4'(b - "A" + 8'd10)};
    return h;
  endfunction

  function automatic logic [6:0] first_kind(input logic [7:0] b);
    logic [6:0] k;
    k = K_NONE;
    unique case (b)
      "+": k = 7'd29; "-": k = 7'd31; "*": k = 7'd33; "%": k = 7'd35;
      "^": k = 7'd37; "~": k = 7'd39; "=": k = 7'd41; "!": k = 7'd43; ":": k = 7'd45;
      ",": k = 7'd49; "?": k = 7'd50; ";": k = 7'd51; "(": k = 7'd52; ")": k = 7'd53;
      "[": k = 7'd54; "]": k = 7'd55; "{": k = 7'd56; "}": k = 7'd57; "#": k = 7'd58;
      "$": k = 7'd59; "@": k = 7'd60;
      ".": k = K_DOT; "&": k = K_AMP; "|": k = K_PIPE; "<": k = K_LESS;
      ">": k = K_GREATER; "/": k = K_SLASH;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_quad(input logic [6:0] k);
    return k == K_AMP || k == K_PIPE || k == K_LESS || k == K_GREATER;
  endfunction

  function automatic logic can_extend(input logic [6:0] k);
    return (k >= 7'd29 && k <= 7'd45 && k[0]) || k == K_DOT || k == K_SLASH || is_quad(k)
      || (k >= 7'd61 && k <= 7'd77 && is_quad(k - 7'd1));
  endfunction

  function automatic logic [6:0] ext_kind(input logic [6:0] k, input logic [7:0] b);
    logic [6:0] e;
    logic [7:0] q;
    e = K_NONE;
    q = k == K_AMP ? "&" : k == K_PIPE ? "|" : k == K_LESS ? "<" : ">";
    if (k >= 7'd29 && k <= 7'd45 && k[0]) e = b == "=" ? k + 7'd1 : K_NONE;
    else if (k == K_DOT) e = b == "." ? K_DOTDOT : K_NONE;
    else if (k == K_SLASH) e = b == "=" ? k + 7'd1 : K_NONE;
    else if (is_quad(k)) e = b == q ? k + 7'd1 : (b == "=" ? k + 7'd3 : K_NONE);
    else if (k >= 7'd61 && k <= 7'd77 && is_quad(k - 7'd1)) e = b == "=" ? k + 7'd1 : K_NONE;
    return e;
  endfunction

  typedef struct packed {
    logic       item_type;
    logic [6:0] kind;
    logic       use_cur;
    logic       dotdot;
    logic       num_short;
    logic [7:0] pay;
  } res_t;

endpackage

@@ rtl/sts_kw_match.sv @@
module sts_kw_match #(
  parameter int unsigned KEYWORD_BYTES = 8
) (
  input  logic [8*KEYWORD_BYTES-1:0] word,
  input  logic [15:0]                len,
  output logic [6:0]                 kind
);
  import sts_pkg::*;

  // kw_str holds the first character in its top used byte
  always_comb begin
    logic hit;
    logic [63:0] ks;
    logic [3:0] kl;
    logic [2:0] bi;
    kind = K_IDENT;
    for (int i = 21; i >= 0; i--) begin
      ks = kw_str(i);
      kl = kw_len(i);
      hit = len == 16'(kl) && len <= 16'(KEYWORD_BYTES);
      for (int j = 0; j < 8; j++) begin
        bi = 3'(kl - 4'(j) - 4'd1);
        if (j < int'(kl) && word[8*j +: 8] != ks[8*bi +: 8]) hit = 1'b0;
      end
      if (hit) kind = 7'(K_KW0 + 7'(i));
    end
  end

endmodule

@@ rtl/source_token_scanner_core.sv @@
// Channel  Ports                                                    Direction
// in       in_valid/in_ready, in_src_byte in_has_byte in_end_of_input into block
// out      out_valid/out_ready, one result per transfer               out of block
// Each item is decoded in the cycle of its transfer; its results, up to four, are
// loaded into an output queue and, from the next cycle on, leave one per cycle
// while out_ready is high. in_ready is high while the queue is empty or its last
// result leaves this cycle, so an item with more than one result holds off the
// input till its last one leaves; items with at most one result flow back to back.
// Synchronous active-low reset returns scanner to line 1, column 1, offset 0.
module source_token_scanner_core #(
  parameter int unsigned MAX_COMMENT_DEPTH = 255,
  parameter int unsigned KEYWORD_BYTES     = 8,
  parameter int unsigned LINE_BITS         = 20,
  parameter int unsigned COLUMN_BITS       = 16,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_src_byte,
  input  logic                   in_has_byte,
  input  logic                   in_end_of_input,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_item_type,
  output logic [6:0]             out_token_kind,
  output logic [LINE_BITS-1:0]   out_start_line,
  output logic [COLUMN_BITS-1:0] out_start_column,
  output logic [OFFSET_BITS-1:0] out_start_offset,
  output logic [15:0]            out_token_length,
  output logic [7:0]             out_payload_byte,
  output logic                   out_last_of_run
);
  import sts_pkg::*;
  `include "source_token_scanner_core_macros.svh"

  localparam int unsigned DB = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam int unsigned WB = $clog2(KEYWORD_BYTES);
  localparam int unsigned RW = 1 + 7 + LINE_BITS + COLUMN_BITS + OFFSET_BITS + 16 + 8 + 1;
  localparam logic [LINE_BITS-1:0]   LMAX = '1;
  localparam logic [COLUMN_BITS-1:0] CMAX = '1;

  mode_t                   mode_r, mode_nxt;
  logic [6:0]              pk_r, pk_nxt;
  logic [LINE_BITS-1:0]    tl_r, tl_nxt, cl_r, cl_nxt;
  logic [COLUMN_BITS-1:0]  tc_r, tc_nxt, cc_r, cc_nxt;
  logic [OFFSET_BITS-1:0]  to_r, to_nxt, co_r, co_nxt;
  logic [15:0]             len_r, len_nxt;
  logic [DB-1:0]           dep_r, dep_nxt;
  logic [8*KEYWORD_BYTES-1:0] wd_r, wd_nxt;
  logic                    dot_r, dot_nxt, qd_r, qd_nxt;
  logic [7:0]              hx_r, hx_nxt;
  logic [6:0]              kwk;
  logic [15:0]             len_inc;
  logic [8*KEYWORD_BYTES-1:0] wd_ext;
  logic [6:0]              kwe;

  // staged result queue
  logic [RW-1:0] q_r [MAX_RES];
  logic [2:0]    qn_r;
  logic [RW-1:0] nr [MAX_RES];
  logic [2:0]    nn;

  sts_kw_match #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_kw (
    .word(wd_r), .len(len_r), .kind(kwk)
  );

  // word extended by the current byte, for a flush at end of input
  assign len_inc = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;

  always_comb begin
    wd_ext = wd_r;
    if (len_r < 16'(KEYWORD_BYTES)) wd_ext[8*len_r[WB-1:0] +: 8] = in_src_byte;
  end

  sts_kw_match #(.KEYWORD_BYTES(KEYWORD_BYTES)) u_kw_ext (
    .word(wd_ext), .len(len_inc), .kind(kwe)
  );

  wire take = in_valid && in_ready;
  wire pop  = out_valid && out_ready;
  assign in_ready = (qn_r == 3'd0) || (qn_r == 3'd1 && out_ready);

  always_comb begin
    logic [7:0] b;
    logic again;
    logic [6:0] e;
    logic [4:0] h;
    logic [15:0] gl;
    logic [COLUMN_BITS+16:0] cs;
    logic [6:0] wk;
    logic [6:0] qk;
    logic [6:0] fk;
    b = in_src_byte;
    mode_nxt = mode_r; pk_nxt = pk_r; tl_nxt = tl_r; tc_nxt = tc_r; to_nxt = to_r;
    len_nxt = len_r; cl_nxt = cl_r; cc_nxt = cc_r; co_nxt = co_r; dep_nxt = dep_r;
    wd_nxt = wd_r; dot_nxt = dot_r; qd_nxt = qd_r; hx_nxt = hx_r;
    nn = 3'd0;
    again = 1'b0;
    for (int i = 0; i < MAX_RES; i++) nr[i] = '0;
    gl = len_inc;
    wk = kwk;
    qk = qd_r ? K_STRING : K_CHAR;
    e = ext_kind(pk_r, b);
    h = hex_val(b);
    cs = (COLUMN_BITS+17)'(tc_r) + (COLUMN_BITS+17)'(len_r) - (COLUMN_BITS+17)'(1);
    fk = !in_has_byte ? wk : (mode_r == M_IDENT) ? kwe : 7'(K_IDENT);

    if (take && in_has_byte) begin
      again = 1'b0;
      unique case (mode_r)
        M_IDENT:
          if (is_word(b)) begin
            if (len_r < 16'(KEYWORD_BYTES)) wd_nxt[8*len_r[WB-1:0] +: 8] = b;
            len_nxt = gl;
          end else begin
            nr[nn[1:0]] = {1'b0, wk, tl_r, tc_r, to_r, len_r, 8'd0, 1'b0}; nn = nn + 3'd1;
            mode_nxt = M_IDLE; again = 1'b1;
          end
        M_NUM:
          if (is_digit(b)) len_nxt = gl;
          else if (b == "." && !dot_r) begin
            dot_nxt = 1'b1; len_nxt = gl; mode_nxt = M_NUM_DOT;
          end else begin
            nr[nn[1:0]] = {1'b0, K_NUMBER, tl_r, tc_r, to_r, len_r, 8'd0, 1'b0};
            nn = nn + 3'd1;
            mode_nxt = M_IDLE; again = 1'b1;
          end
        M_NUM_DOT:
          if (is_digit(b)) begin
            len_nxt = gl; mode_nxt = M_NUM;
          end else if (b == ".") begin
            nr[0] = {1'b0, K_NUMBER, tl_r, tc_r, to_r, len_r - 16'd1, 8'd0, 1'b0};
            nr[1] = {1'b0, K_DOTDOT, tl_r,
                     (cs > (COLUMN_BITS+17)'(CMAX)) ? CMAX : COLUMN_BITS'(cs),
                     to_r + OFFSET_BITS'(len_r) - OFFSET_BITS'(1), 16'd2, 8'd0, 1'b0};
            nn = 3'd2; mode_nxt = M_IDLE;
          end else begin
            nr[nn[1:0]] = {1'b0, K_NUMBER, tl_r, tc_r, to_r, len_r, 8'd0, 1'b0};
            nn = nn + 3'd1;
            mode_nxt = M_IDLE; again = 1'b1;
          end
        M_OP:
          if (pk_r == K_SLASH && b == "/") mode_nxt = M_LINE;
          else if (pk_r == K_SLASH && b == "*") begin
            dep_nxt = DB'(1); mode_nxt = M_BLK;
          end else if (e != K_NONE) begin
            len_nxt = gl;
            if (can_extend(e)) pk_nxt = e;
            else begin
              nr[nn[1:0]] = {1'b0, e, tl_r, tc_r, to_r, gl, 8'd0, 1'b0}; nn = nn + 3'd1;
              mode_nxt = M_IDLE;
            end
          end else begin
            nr[nn[1:0]] = {1'b0, pk_r, tl_r, tc_r, to_r, len_r, 8'd0, 1'b0}; nn = nn + 3'd1;
            mode_nxt = M_IDLE; again = 1'b1;
          end
        M_STR: begin
          len_nxt = gl;
          if (b == (qd_r ? 8'h22 : 8'h27)) begin
            nr[nn[1:0]] = {1'b0, qk, tl_r, tc_r, to_r, gl, 8'd0, 1'b0};
            nn = nn + 3'd1; mode_nxt = M_IDLE;
          end else if (b == 8'h5C) mode_nxt = M_STR_ESC;
          else begin
            nr[nn[1:0]] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, b, 1'b0};
            nn = nn + 3'd1;
          end
        end
        M_STR_ESC: begin
          len_nxt = gl; mode_nxt = M_STR;
          unique case (b)
            "n": begin nr[0] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, 8'd10, 1'b0}; nn = 3'd1; end
            "r": begin nr[0] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, 8'd13, 1'b0}; nn = 3'd1; end
            "t": begin nr[0] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, 8'd9, 1'b0}; nn = 3'd1; end
            "0": begin nr[0] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, 8'd0, 1'b0}; nn = 3'd1; end
            8'h5C, 8'h27, 8'h22: begin
              nr[0] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, b, 1'b0}; nn = 3'd1;
            end
            "x", "X": begin hx_nxt = 8'd0; mode_nxt = M_STR_HEX; end
            default: begin
              nr[0] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, 8'h5C, 1'b0};
              nr[1] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, b, 1'b0};
              nn = 3'd2;
            end
          endcase
        end
        M_STR_HEX:
          if (!h[4]) begin
            len_nxt = gl; hx_nxt = {hx_r[3:0], 4'd0} + {4'd0, h[3:0]};
          end else begin
            nr[0] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, hx_r, 1'b0};
            nn = 3'd1; mode_nxt = M_STR; len_nxt = gl;
            if (b == (qd_r ? 8'h22 : 8'h27)) begin
              nr[1] = {1'b0, qk, tl_r, tc_r, to_r, gl, 8'd0, 1'b0};
              nn = 3'd2; mode_nxt = M_IDLE;
            end else if (b == 8'h5C) mode_nxt = M_STR_ESC;
            else begin
              nr[1] = {1'b1, qk, tl_r, tc_r, to_r, 16'd0, b, 1'b0};
              nn = 3'd2;
            end
          end
        M_LINE:
          if (b == 8'd13 || b == 8'd10) mode_nxt = M_IDLE;
        M_BLK:
          if (b == "/") mode_nxt = M_BLK_SLASH;
          else if (b == "*") mode_nxt = M_BLK_STAR;
        M_BLK_SLASH:
          if (b == "*") begin
            if (dep_r < DB'(MAX_COMMENT_DEPTH)) dep_nxt = dep_r + DB'(1);
            mode_nxt = M_BLK;
          end else if (b != "/") mode_nxt = M_BLK;
        M_BLK_STAR:
          if (b == "/") begin
            if (dep_r != '0) dep_nxt = dep_r - DB'(1);
            mode_nxt = (dep_r <= DB'(1)) ? M_IDLE : M_BLK;
          end else if (b != "*") mode_nxt = M_BLK;
        default: again = 1'b1;
      endcase
      if (again && !is_skip(b)) begin
        tl_nxt = cl_r; tc_nxt = cc_r; to_nxt = co_r; len_nxt = 16'd1;
        mode_nxt = M_IDLE;
        if (is_alpha(b) || b == "_") begin
          wd_nxt[7:0] = b; mode_nxt = M_IDENT;
        end else if (is_digit(b)) begin
          dot_nxt = 1'b0; mode_nxt = M_NUM;
        end else if (b == 8'h22 || b == 8'h27) begin
          qd_nxt = b == 8'h22; mode_nxt = M_STR;
        end else if (first_kind(b) == K_NONE) begin
          nr[nn[1:0]] = {1'b0, K_UNKNOWN, cl_r, cc_r, co_r, 16'd1, 8'd0, 1'b0};
          nn = nn + 3'd1;
        end else if (can_extend(first_kind(b))) begin
          pk_nxt = first_kind(b); mode_nxt = M_OP;
        end else begin
          nr[nn[1:0]] = {1'b0, first_kind(b), cl_r, cc_r, co_r, 16'd1, 8'd0, 1'b0};
          nn = nn + 3'd1;
        end
      end else if (again) mode_nxt = M_IDLE;
      co_nxt = co_r + OFFSET_BITS'(1);
      if (b == 8'd10) begin
        if (cl_r != LMAX) cl_nxt = cl_r + LINE_BITS'(1);
        cc_nxt = COLUMN_BITS'(1);
      end else if (cc_r != CMAX) cc_nxt = cc_r + COLUMN_BITS'(1);
    end
    if (take && in_end_of_input) begin
      // flush uses post-byte state
      unique case (mode_nxt)
        M_IDENT: begin
          nr[nn[1:0]] = {1'b0, fk, tl_nxt, tc_nxt, to_nxt, len_nxt, 8'd0, 1'b0};
          nn = nn + 3'd1;
        end
        M_NUM, M_NUM_DOT: begin
          nr[nn[1:0]] = {1'b0, K_NUMBER, tl_nxt, tc_nxt, to_nxt, len_nxt, 8'd0, 1'b0};
          nn = nn + 3'd1;
        end
        M_OP: begin
          nr[nn[1:0]] = {1'b0, pk_nxt, tl_nxt, tc_nxt, to_nxt, len_nxt, 8'd0, 1'b0};
          nn = nn + 3'd1;
        end
        M_STR_HEX: begin
          nr[nn[1:0]] = {1'b1, qd_nxt ? K_STRING : K_CHAR, tl_nxt, tc_nxt, to_nxt, 16'd0,
                         hx_nxt, 1'b0};
          nr[2'(nn + 3'd1)] = {1'b0, K_ERROR, tl_nxt, tc_nxt, to_nxt, len_nxt, 8'd0, 1'b0};
          nn = nn + 3'd2;
        end
        M_STR, M_STR_ESC: begin
          nr[nn[1:0]] = {1'b0, K_ERROR, tl_nxt, tc_nxt, to_nxt, len_nxt, 8'd0, 1'b0};
          nn = nn + 3'd1;
        end
        default: ;
      endcase
      nr[nn[1:0]] = {1'b0, K_EOF, cl_nxt, cc_nxt, co_nxt, 16'd0, 8'd0, 1'b0};
      nn = nn + 3'd1;
      mode_nxt = M_IDLE; pk_nxt = '0; tl_nxt = LINE_BITS'(1); tc_nxt = COLUMN_BITS'(1);
      to_nxt = '0; len_nxt = '0; cl_nxt = LINE_BITS'(1); cc_nxt = COLUMN_BITS'(1);
      co_nxt = '0; dep_nxt = '0; wd_nxt = '0; dot_nxt = 1'b0; hx_nxt = '0; qd_nxt = 1'b0;
    end
    if (nn != 3'd0) nr[2'(nn - 3'd1)][0] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pk_r <= '0; tl_r <= LINE_BITS'(1); tc_r <= COLUMN_BITS'(1);
      to_r <= '0; len_r <= '0; cl_r <= LINE_BITS'(1); cc_r <= COLUMN_BITS'(1);
      co_r <= '0; dep_r <= '0; wd_r <= '0; dot_r <= 1'b0; hx_r <= '0; qd_r <= 1'b0;
      qn_r <= '0;
    end else begin
      mode_r <= mode_nxt; pk_r <= pk_nxt; tl_r <= tl_nxt; tc_r <= tc_nxt; to_r <= to_nxt;
      len_r <= len_nxt; cl_r <= cl_nxt; cc_r <= cc_nxt; co_r <= co_nxt; dep_r <= dep_nxt;
      wd_r <= wd_nxt; dot_r <= dot_nxt; hx_r <= hx_nxt; qd_r <= qd_nxt;
      if (take) qn_r <= nn;
      else if (pop) qn_r <= qn_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RES; i++) q_r[i] <= nr[i];
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) q_r[i] <= q_r[i+1];
    end
  end

  assign out_valid = qn_r != 3'd0;
  assign {out_item_type, out_token_kind, out_start_line, out_start_column, out_start_offset,
          out_token_length, out_payload_byte, out_last_of_run} = q_r[0];

  `STS_ASSERT(a_qn_max, clk, rst_n, qn_r <= 3'd4, "queue count out of range")
  `STS_ASSERT(a_ready, clk, rst_n, in_ready |-> (qn_r <= 3'd1), "ready with pending results")
  `STS_ASSERT(a_mode, clk, rst_n, $onehot(mode_r), "mode not one-hot")
  `STS_ASSERT(a_eof, clk, rst_n, (take && in_end_of_input) |=> (mode_r == M_IDLE && co_r == '0), "no reset after end of input")

endmodule
